/* hdl/cal_pkg.sv */
// Shared types and codes for the cursor array list.
package cal_pkg;

	typedef enum logic [3:0] {
		OP_INSERT   = 4'd0,
		OP_APPEND   = 4'd1,
		OP_REMOVE   = 4'd2,
		OP_TO_START = 4'd3,
		OP_TO_END   = 4'd4,
		OP_PREV     = 4'd5,
		OP_NEXT     = 4'd6,
		OP_MOVE_TO  = 4'd7,
		OP_READ_AT  = 4'd8,
		OP_CLEAR    = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_NOELEM = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [31:0] value;
		logic [7:0]  pos;
	} req_t;

	typedef struct packed {
		logic [31:0] data;
		status_t     status;
		logic [7:0]  length;
		logic [7:0]  cursor;
	} rsp_t;

endpackage

/* hdl/cal_mem.sv */
// Entry storage: one write port, one read port with registered read data.
module cal_mem #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/cursor_array_list.sv */
// Cursor array list: ordered word list with cursor, one item at a time.
// Cursor moves, append, clear and errors respond from the execute state;
// read_at passes the read-wait state first, an insert at the end of the list
// the insert-write state; other inserts shift entries up before it and removes
// shift them down, one entry per cycle through the single-port-pair memory.
// A new item is taken in the cycle after the previous result is registered.
// Reset clears count, cursor and control; entry contents are not cleared.
module cursor_array_list
	import cal_pkg::*;
#(
	parameter int CAPACITY  = 128,
	parameter int WORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 8) ? CW : 8;
	localparam int NB = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_UP,
		S_INSWR,
		S_DN,
		S_RMDONE,
		S_RDWAIT
	} state_t;

	state_t               state_q;
	logic [3:0]           op_q;
	logic [WORD_BITS-1:0] val_q;
	logic [7:0]           pos_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        cur_q;
	logic [AW-1:0]        idx_q;
	logic [AW-1:0]        wa_q;
	logic                 pend_q;
	logic                 issue_q;
	logic                 first_q;
	logic [31:0]          data_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] rd_data;
	logic [WORD_BITS-1:0] val_w;
	logic [31:0]          rd32;
	logic                 out_free;
	logic                 full;

	function automatic rsp_t mk_rsp(logic [31:0] d, status_t s,
			logic [CW-1:0] n, logic [CW-1:0] c);
		rsp_t r;
		r.data   = d;
		r.status = s;
		r.length = 8'(n);
		r.cursor = 8'(c);
		return r;
	endfunction

	always_comb begin
		val_w = '0;
		for (int i = 0; i < NB; i++) val_w[i] = req.value[i];
		rd32 = '0;
		for (int i = 0; i < NB; i++) rd32[i] = rd_data[i];
	end

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign full      = (cnt_q >= CAP_C);
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wa_q;
		mem_wdata = rd_data;
		mem_raddr = idx_q;
		unique case (state_q)
			S_EXEC: begin
				mem_raddr = AW'(pos_q);
				mem_waddr = cnt_q[AW-1:0];
				mem_wdata = val_q;
				mem_we    = out_free && (op_q == OP_APPEND) && !full;
			end
			S_UP:    mem_we = pend_q;
			S_INSWR: begin
				mem_waddr = cur_q[AW-1:0];
				mem_wdata = val_q;
				mem_we    = out_free;
			end
			S_DN:    mem_we = pend_q && !first_q;
			default: mem_we = 1'b0;
		endcase
	end

	cal_mem #(
		.WIDTH(WORD_BITS),
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			cur_q       <= '0;
			pend_q      <= 1'b0;
			issue_q     <= 1'b0;
			first_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q    <= req.req_type;
						val_q   <= val_w;
						pos_q   <= req.pos;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
						unique case (op_q)
							OP_INSERT: begin
								if (full) begin
									rsp_valid_q <= 1'b1;
									rsp_q <= mk_rsp('0, ST_FULL, cnt_q, cur_q);
								end else if (cur_q == cnt_q) begin
									state_q <= S_INSWR;
								end else begin
									// shift up from the top entry down to the cursor
									idx_q   <= AW'(cnt_q - 1'b1);
									issue_q <= 1'b1;
									pend_q  <= 1'b0;
									state_q <= S_UP;
								end
							end
							OP_APPEND: begin
								rsp_valid_q <= 1'b1;
								if (full) begin
									rsp_q <= mk_rsp('0, ST_FULL, cnt_q, cur_q);
								end else begin
									cnt_q <= cnt_q + 1'b1;
									rsp_q <= mk_rsp('0, ST_OK, cnt_q + 1'b1, cur_q);
								end
							end
							OP_REMOVE: begin
								if (cur_q >= cnt_q) begin
									rsp_valid_q <= 1'b1;
									rsp_q <= mk_rsp('0, ST_NOELEM, cnt_q, cur_q);
								end else begin
									idx_q   <= cur_q[AW-1:0];
									issue_q <= 1'b1;
									pend_q  <= 1'b0;
									state_q <= S_DN;
								end
							end
							OP_TO_START: begin
								cur_q       <= '0;
								rsp_valid_q <= 1'b1;
								rsp_q       <= mk_rsp('0, ST_OK, cnt_q, '0);
							end
							OP_TO_END: begin
								cur_q       <= cnt_q;
								rsp_valid_q <= 1'b1;
								rsp_q       <= mk_rsp('0, ST_OK, cnt_q, cnt_q);
							end
							OP_PREV: begin
								rsp_valid_q <= 1'b1;
								if (cur_q != '0) begin
									cur_q <= cur_q - 1'b1;
									rsp_q <= mk_rsp('0, ST_OK, cnt_q, cur_q - 1'b1);
								end else begin
									rsp_q <= mk_rsp('0, ST_OK, cnt_q, cur_q);
								end
							end
							OP_NEXT: begin
								rsp_valid_q <= 1'b1;
								if (cur_q < cnt_q) begin
									cur_q <= cur_q + 1'b1;
									rsp_q <= mk_rsp('0, ST_OK, cnt_q, cur_q + 1'b1);
								end else begin
									rsp_q <= mk_rsp('0, ST_OK, cnt_q, cur_q);
								end
							end
							OP_MOVE_TO: begin
								rsp_valid_q <= 1'b1;
								if (XW'(pos_q) > XW'(cnt_q)) begin
									rsp_q <= mk_rsp('0, ST_RANGE, cnt_q, cur_q);
								end else begin
									cur_q <= CW'(pos_q);
									rsp_q <= mk_rsp('0, ST_OK, cnt_q, CW'(pos_q));
								end
							end
							OP_READ_AT: begin
								if (XW'(pos_q) >= XW'(cnt_q)) begin
									rsp_valid_q <= 1'b1;
									rsp_q <= mk_rsp('0, ST_NOELEM, cnt_q, cur_q);
								end else begin
									idx_q   <= AW'(pos_q);
									state_q <= S_RDWAIT;
								end
							end
							OP_CLEAR: begin
								cnt_q       <= '0;
								cur_q       <= '0;
								rsp_valid_q <= 1'b1;
								rsp_q       <= mk_rsp('0, ST_OK, '0, '0);
							end
							default: begin
								rsp_valid_q <= 1'b1;
								rsp_q       <= mk_rsp('0, ST_OK, cnt_q, cur_q);
							end
						endcase
					end
				end
				S_UP: begin
					// read idx, write what was read last cycle one slot higher
					if (issue_q) begin
						wa_q   <= idx_q + 1'b1;
						pend_q <= 1'b1;
						if (idx_q == cur_q[AW-1:0]) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_INSWR;
					end
				end
				S_INSWR: begin
					if (out_free) begin
						cnt_q       <= cnt_q + 1'b1;
						rsp_valid_q <= 1'b1;
						rsp_q       <= mk_rsp('0, ST_OK, cnt_q + 1'b1, cur_q);
						state_q     <= S_IDLE;
					end
				end
				S_DN: begin
					// first read is the removed entry, the rest move down one slot
					if (pend_q && first_q) begin
						data_q <= rd32;
					end
					if (issue_q) begin
						wa_q    <= idx_q - 1'b1;
						pend_q  <= 1'b1;
						first_q <= (idx_q == cur_q[AW-1:0]);
						if (idx_q == AW'(cnt_q - 1'b1)) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_RMDONE;
					end
				end
				S_RMDONE: begin
					if (out_free) begin
						cnt_q       <= cnt_q - 1'b1;
						rsp_valid_q <= 1'b1;
						rsp_q       <= mk_rsp(data_q, ST_OK, cnt_q - 1'b1, cur_q);
						state_q     <= S_IDLE;
					end
				end
				S_RDWAIT: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= mk_rsp(rd32, ST_OK, cnt_q, cur_q);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cur_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= cnt_q)
		else $error("cursor beyond count");

	a_cnt_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_C)
		else $error("count beyond capacity");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("memory write while idle");

	a_cnt_with_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> rsp_valid_q)
		else $error("count changed without a result");

	a_up_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP && pend_q) |-> (CW'(wa_q) <= cnt_q))
		else $error("shift write past list end");
`endif

endmodule
